>>> rtl/sha256_message_hasher_macros.svh
// Assertion macros shared by the SHA-256 hasher RTL.
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/sha256mh_pkg.sv
// Constants of the SHA-256 algorithm: round constants, initial hash and padding.
`default_nettype none
package sha256mh_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LengthPos = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;

  // Rotate right by a constant amount.
  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha256mh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sha256mh_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/sha256_message_hasher.sv
// SHA-256 hasher: takes a message one byte per word and returns the 256-bit digest.
//
// The hasher takes one message byte per input word; a byte that neither closes a
// 64-byte block nor is marked final leaves the input ready for the next word. Bytes
// are packed into 32-bit words and kept in a 16-entry block RAM. When a block fills,
// the input stalls while it is hashed: a load state starts the RAM read, then come 64
// compression rounds at one round per cycle (message schedule words come from the RAM
// for the first 16 rounds and from a 16-deep shift line after that), and a fold state
// folds the result into the hash. A word marked final latches the length, then pads
// the block byte by byte up to its end, hashes each padding block (one or two) as
// above, and then gives eight digest words, word 0 first, one per cycle that the output
// is not stalled. The hash then returns to the initial values for the next message.
`default_nettype none
`include "sha256_message_hasher_macros.svh"
module sha256_message_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  message_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        final_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [31:0] digest_word_o,
  output logic      [2:0]  word_number_o,
  output logic             last_word_o
);
  import sha256mh_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StPadGo  = 3'd1;
  localparam logic [2:0] StPad    = 3'd2;
  localparam logic [2:0] StLoad   = 3'd3;
  localparam logic [2:0] StRound  = 3'd4;
  localparam logic [2:0] StFold   = 3'd5;
  localparam logic [2:0] StOut    = 3'd6;

  logic [2:0]  state_q, state_d, ret_q, ret_d;
  logic [5:0]  fill_q, rnd_q;
  logic [23:0] part_q;
  logic [54:0] blk_q;
  logic [63:0] len_q;
  logic        first_q, lenok_q;
  logic [2:0]  idx_q;
  logic [31:0] hash_q [8];
  logic [31:0] s_q [8];
  logic [31:0] w_q [16];

  logic        in_acc, out_acc;
  logic        ins_en, wr_en, blk_full;
  logic [7:0]  ins_byte;
  logic [31:0] wr_word, rd_word;
  logic [3:0]  rd_addr;
  logic [31:0] w_new, w_t, t1, t2;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Byte insertion path shared by message bytes and padding.
  always_comb begin
    ins_en   = 1'b0;
    ins_byte = 8'h00;
    if (state_q == StIdle) begin
      ins_en   = in_acc && byte_present_i;
      ins_byte = message_byte_i;
    end else if (state_q == StPad) begin
      ins_en = 1'b1;
      if (first_q) begin
        ins_byte = PadByte;
      end else if (lenok_q && fill_q >= LengthPos) begin
        ins_byte = len_q[63:56];
      end
    end
  end

  assign wr_word  = {part_q, ins_byte};
  assign wr_en    = ins_en && (fill_q[1:0] == 2'd3);
  assign blk_full = ins_en && (fill_q == LastPos);
  assign rd_addr  = (state_q == StRound) ? (rnd_q[3:0] + 4'd1) : 4'd0;

  sha256mh_ram #(.Width(32), .Depth(16)) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (fill_q[5:2]),
    .wdata_i (wr_word),
    .raddr_i (rd_addr),
    .rdata_o (rd_word)
  );

  // Message schedule and one compression round.
  always_comb begin
    w_new = (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10)) + w_q[9]
          + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[0];
    w_t   = (rnd_q[5:4] == 2'd0) ? rd_word : w_new;
    t1 = s_q[7] + (rotr(s_q[4], 6) ^ rotr(s_q[4], 11) ^ rotr(s_q[4], 25))
       + ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6])) + RoundK[rnd_q] + w_t;
    t2 = (rotr(s_q[0], 2) ^ rotr(s_q[0], 13) ^ rotr(s_q[0], 22))
       + ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (blk_full) begin
            state_d = StLoad;
            ret_d   = final_item_i ? StPadGo : StIdle;
          end else if (final_item_i) begin
            state_d = StPadGo;
          end
        end
      end
      StPadGo: state_d = StPad;
      StPad: begin
        if (blk_full) begin
          state_d = StLoad;
          ret_d   = (!first_q && lenok_q) ? StOut : StPad;
        end
      end
      StLoad:  state_d = StRound;
      StRound: if (rnd_q == 6'd63) state_d = StFold;
      StFold:  state_d = ret_q;
      StOut:   if (out_acc && idx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      fill_q  <= '0;
      rnd_q   <= '0;
      blk_q   <= '0;
      first_q <= 1'b0;
      lenok_q <= 1'b0;
      idx_q   <= '0;
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (ins_en) fill_q <= fill_q + 6'd1;
      if (state_q == StPadGo) first_q <= 1'b1;
      if (state_q == StPad) begin
        first_q <= 1'b0;
        // Any block that follows a completed one has room for the length.
        if (blk_full) lenok_q <= 1'b1;
        else if (first_q) lenok_q <= (fill_q < LengthPos);
      end
      if (state_q == StLoad) rnd_q <= '0;
      else if (state_q == StRound) rnd_q <= rnd_q + 6'd1;
      if (state_q == StFold) begin
        blk_q <= blk_q + 55'd1;
        for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + s_q[i];
      end
      if (out_acc) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          blk_q <= '0;
          for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
        end
      end
    end
  end

  // Datapath registers: partial word, length, working variables, schedule.
  always_ff @(posedge clk_i) begin
    if (ins_en) part_q <= wr_word[23:0];
    if (state_q == StPadGo) len_q <= {blk_q, fill_q, 3'b000};
    else if (state_q == StPad && !first_q && lenok_q && fill_q >= LengthPos) begin
      len_q <= {len_q[55:0], 8'h00};
    end
    if (state_q == StLoad) begin
      for (int i = 0; i < 8; i++) s_q[i] <= hash_q[i];
    end else if (state_q == StRound) begin
      s_q[0] <= t1 + t2;
      s_q[1] <= s_q[0];
      s_q[2] <= s_q[1];
      s_q[3] <= s_q[2];
      s_q[4] <= s_q[3] + t1;
      s_q[5] <= s_q[4];
      s_q[6] <= s_q[5];
      s_q[7] <= s_q[6];
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_t;
    end
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = hash_q[idx_q];
  assign word_number_o = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  `SHA_ASSERT_NXT(a_round_end, clk_i, rst_ni, state_q == StRound && rnd_q == 6'd63, state_q == StFold)
  `SHA_ASSERT_IMP(a_wr_only_insert, clk_i, rst_ni, wr_en, state_q == StIdle || state_q == StPad)
  `SHA_ASSERT_NXT(a_last_done, clk_i, rst_ni, out_acc && last_word_o, !out_valid_o && fill_q == 6'd0)
  `SHA_ASSERT_IMP(a_fold_at_block_end, clk_i, rst_ni, state_q == StLoad, fill_q == 6'd0)

endmodule
`default_nettype wire

>>> tb/sv/sha256_digest_checker.sv
// Checker that watches the hasher's channels, predicts each digest and compares it.
module sha256_digest_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [7:0]  message_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        final_item_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [31:0] digest_word_i,
  input  wire logic [2:0]  word_number_i,
  input  wire logic        last_word_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sha256mh_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] bits_done;
  logic [31:0] chain [8];
  digest_word_t digest_queue [$];

  function automatic logic [31:0] ror32(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // One 64-round compression of the current block into the chaining words.
  task automatic fold_block();
    logic [31:0] w [64];
    logic [31:0] s [8];
    logic [31:0] t1, t2, x, y;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10)) + w[i-7] +
             (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[i-16];
    end
    s = chain;
    for (int i = 0; i < 64; i++) begin
      t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25)) +
           ((s[4] & s[5]) ^ (~s[4] & s[6])) + RoundK[i] + w[i];
      t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22)) +
           ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
      s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + s[i];
  endtask

  task automatic restart_message();
    block_fill = 0;
    bits_done = '0;
    for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
  endtask

  // Absorb one accepted word; on a final word pad and queue the digest.
  task automatic absorb_word(logic [7:0] b, logic present, logic fin);
    int pos;
    logic [63:0] len;
    digest_word_t d;
    if (present) begin
      msg_block[block_fill] = b;
      block_fill++;
      if (block_fill == 64) begin
        fold_block();
        bits_done += 64'd512;
        block_fill = 0;
      end
    end
    if (fin) begin
      pos = block_fill;
      len = bits_done + 64'(pos) * 64'd8;
      msg_block[pos++] = PadByte;
      if (pos > 56) begin
        while (pos < 64) msg_block[pos++] = 8'h00;
        fold_block();
        pos = 0;
      end
      while (pos < 56) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = len[63-8*i -: 8];
      fold_block();
      for (int i = 0; i < 8; i++) begin
        d.word = chain[i];
        d.index = 3'(i);
        d.last = (i == 7);
        digest_queue.push_back(d);
      end
      restart_message();
    end
  endtask

  initial begin
    fail_count_o = 0;
    restart_message();
  end

  assign pending_o = digest_queue.size();

  // Sample both channels at each rising edge.
  always @(posedge clk_i) begin
    digest_word_t exp_w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        absorb_word(message_byte_i, byte_present_i, final_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest word actual %h/%0d/%0b", $time,
                   digest_word_i, word_number_i, last_word_i);
          fail_count_o++;
        end else begin
          exp_w = digest_queue.pop_front();
          if (exp_w.word !== digest_word_i) begin
            $display("%0t: digest_word expected %h actual %h", $time, exp_w.word,
                     digest_word_i);
            fail_count_o++;
          end
          if (exp_w.index !== word_number_i) begin
            $display("%0t: word_number expected %0d actual %0d", $time, exp_w.index,
                     word_number_i);
            fail_count_o++;
          end
          if (exp_w.last !== last_word_i) begin
            $display("%0t: last_word expected %0b actual %0b", $time, exp_w.last,
                     last_word_i);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/tb.sv
// Testbench top: drives messages into the SHA-256 hasher and reports the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  message_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        final_item_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_number_o;
  logic        last_word_o;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          byte_total = 0;
  bit          calm_phase = 1'b0;
  bit          long_hold = 1'b0;

  localparam int CycleLimit = 1500000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sha256_message_hasher dut (.*);

  sha256_digest_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .message_byte_i,
    .byte_present_i, .final_item_i, .out_valid_i(out_valid_o), .out_stall_i,
    .digest_word_i(digest_word_o), .word_number_i(word_number_o),
    .last_word_i(last_word_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else
        out_stall_i <= !calm_phase && ($urandom_range(99) < 10);
    end
  end

  // Send one word and wait for it to be accepted, with random gaps before it.
  task automatic send_word(logic [7:0] b, logic present, logic fin);
    while (!calm_phase && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    message_byte_i <= b;
    byte_present_i <= present;
    final_item_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    byte_total++;
  endtask

  task automatic send_message(int len, int mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      if (i == len - 1) send_word(b, 1'b1, 1'b1);
      else send_word(b, 1'b1, 1'b0);
      if ($urandom_range(99) < 3) send_word(8'($urandom), 1'b0, 1'b0);
    end
    if (len == 0) send_word(8'($urandom), 1'b0, 1'b1);
    else if ($urandom_range(99) < 10) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int lens [$] = '{0, 1, 55, 56, 63, 64};
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: padding edges, empty message, all-zero and all-one bytes.
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_message(3, 0);
    send_message(3, 1);
    foreach (lens[i]) send_message(lens[i], 2);
    // Let the output back up while input keeps coming.
    long_hold = 1'b1;
    for (int k = 0; k < 6; k++) send_message(2, 2);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // Random short messages; the first few run without any idling.
    n = 0;
    while (byte_total < 330) begin
      calm_phase = (n < 5);
      send_message($urandom_range(0, 10), 2);
      n++;
    end
    calm_phase = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/sha256mh_pkg.sv
rtl/sha256mh_ram.sv
rtl/sha256_message_hasher.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb.sv
